// ===== design/ctdd_pkg.sv =====
package ctdd_pkg;

   // Slot table geometry
   localparam int NUM_SLOTS  = 4;
   localparam int SLOT_W     = 2;
   localparam int SLOT_CNT_W = 3;

   // Field widths
   localparam int COUNT_W   = 16;
   localparam int HOLDOFF_W = 8;
   localparam int KIND_W    = 2;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

   // Configuration register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH_SLOT0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH_SLOT1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH_SLOT2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESH_SLOT3 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF      = 3'd5;

   // Register reset values
   localparam logic [SLOT_CNT_W-1:0] SLOTS_IN_USE_RST = 3'd4;
   localparam logic [HOLDOFF_W-1:0]  HOLDOFF_RST      = 8'd100;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COUNT_W-1:0] count;
      logic [SLOT_W-1:0]  slot;
   } req_type;

   typedef struct packed {
      logic                      touched;
      logic signed [COUNT_W-1:0] difference;
      logic [SLOT_W-1:0]         next_slot;
   } rsp_type;

endpackage

// ===== design/cap_touch_delta_detector_unit.sv =====
// A request's response is registered in the output stage, or in the skid stage while the output stage is held.
// Throughput: one request per cycle; the slot table is updated in a single
// pass at acceptance, and a skid entry takes one more request while a
// response waits, so the input stalls only once both entries are full.
// Reset (synchronous, active high) clears the slot table, hold-off counters,
// active slot and output buffer valid flags, and loads the register defaults.
module cap_touch_delta_detector_unit
   import ctdd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers
   logic [SLOT_CNT_W-1:0]     slots_in_use_ff;
   logic signed [COUNT_W-1:0] thresh_ff [NUM_SLOTS];
   logic [HOLDOFF_W-1:0]      holdoff_ticks_ff;

   // Slot table
   logic [COUNT_W-1:0]   prior_ff   [NUM_SLOTS];
   logic [COUNT_W-1:0]   current_ff [NUM_SLOTS];
   logic [HOLDOFF_W-1:0] holdoff_ff [NUM_SLOTS];
   logic [SLOT_W-1:0]    active_ff;

   logic [COUNT_W-1:0]   prior_in   [NUM_SLOTS];
   logic [COUNT_W-1:0]   current_in [NUM_SLOTS];
   logic [HOLDOFF_W-1:0] holdoff_in [NUM_SLOTS];
   logic [SLOT_W-1:0]    active_in;

   // Output buffer: main stage plus skid stage
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   logic                      accept;
   logic [SLOT_CNT_W-1:0]     used;
   logic [SLOT_CNT_W-1:0]     active_inc;
   logic signed [COUNT_W-1:0] diff;
   logic                      touch_in;
   rsp_type                   rsp_in;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Effective number of slots: zero counts as one, clamp at the table size
   always_comb begin
      if (slots_in_use_ff == '0) begin
         used = SLOT_CNT_W'(1);
      end else if (slots_in_use_ff > SLOT_CNT_W'(NUM_SLOTS)) begin
         used = SLOT_CNT_W'(NUM_SLOTS);
      end else begin
         used = slots_in_use_ff;
      end
   end

   assign active_inc = SLOT_CNT_W'(active_ff) + SLOT_CNT_W'(1);
   assign diff       = prior_ff[req_data.slot] - current_ff[req_data.slot];

   // Single pass over the slot table for the accepted request
   always_comb begin
      prior_in   = prior_ff;
      current_in = current_ff;
      holdoff_in = holdoff_ff;
      active_in  = active_ff;
      touch_in   = 1'b0;
      rsp_in.touched    = 1'b0;
      rsp_in.difference = '0;
      case (req_data.kind)
         KIND_SCAN: begin
            prior_in[active_ff]   = current_ff[active_ff];
            current_in[active_ff] = req_data.count;
            active_in = (active_inc >= used) ? '0 : active_inc[SLOT_W-1:0];
         end
         KIND_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (SLOT_CNT_W'(i) < used && holdoff_ff[i] != '0) begin
                  holdoff_in[i] = holdoff_ff[i] - HOLDOFF_W'(1);
               end
            end
         end
         KIND_CHECK: begin
            if (SLOT_CNT_W'(req_data.slot) < used) begin
               rsp_in.difference = diff;
               if (diff > thresh_ff[req_data.slot] && holdoff_ff[req_data.slot] == '0) begin
                  touch_in = 1'b1;
                  holdoff_in[req_data.slot] = holdoff_ticks_ff;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_in.touched   = touch_in;
      rsp_in.next_slot = active_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff  <= SLOTS_IN_USE_RST;
         holdoff_ticks_ff <= HOLDOFF_RST;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            thresh_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_wdata[SLOT_CNT_W-1:0];
            CSR_THRESH_SLOT0: thresh_ff[0] <= csr_wdata;
            CSR_THRESH_SLOT1: thresh_ff[1] <= csr_wdata;
            CSR_THRESH_SLOT2: thresh_ff[2] <= csr_wdata;
            CSR_THRESH_SLOT3: thresh_ff[3] <= csr_wdata;
            CSR_HOLDOFF:      holdoff_ticks_ff <= csr_wdata[HOLDOFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Slot table update
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            prior_ff[i]   <= '0;
            current_ff[i] <= '0;
            holdoff_ff[i] <= '0;
         end
      end else if (accept) begin
         active_ff  <= active_in;
         prior_ff   <= prior_in;
         current_ff <= current_in;
         holdoff_ff <= holdoff_in;
      end
   end

   // Output buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Output buffer data
   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (accept) begin
            out_data_ff <= rsp_in;
         end
      end else if (accept) begin
         skid_data_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // Skid stage only fills behind a held main stage
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output stage empty");

   // A reported touch reloads that slot's hold-off
   assert property (@(posedge clock) disable iff (reset)
      accept && touch_in |=> holdoff_ff[$past(req_data.slot)] == holdoff_ticks_ff)
      else $error("hold-off not reloaded after touch");

   // A scan stores its count in the slot that was active
   assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_SCAN |=>
         current_ff[$past(active_ff)] == $past(req_data.count))
      else $error("scan count not stored in active slot");

   // A response is never dropped while the consumer stalls
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled response lost");
`endif

endmodule

// ===== verif/tb_cap_touch_delta_detector_unit.sv =====
`timescale 1ns / 1ps

import ctdd_pkg::*;

// Tracks the slot table alongside the block and holds the responses still owed
class touch_result_tracker;
   logic [SLOT_CNT_W-1:0]       slots_cfg;
   logic signed [COUNT_W-1:0]   thresh [NUM_SLOTS];
   logic [HOLDOFF_W-1:0]        holdoff_reload;
   logic [COUNT_W-1:0]          prior_cnt [NUM_SLOTS];
   logic [COUNT_W-1:0]          current_cnt [NUM_SLOTS];
   logic [HOLDOFF_W-1:0]        holdoff_left [NUM_SLOTS];
   int                          active;
   rsp_type                     owed_responses [$];
   int                          failures;

   function new();
      slots_cfg      = SLOTS_IN_USE_RST;
      holdoff_reload = HOLDOFF_RST;
      active         = 0;
      failures       = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         thresh[i]       = '0;
         prior_cnt[i]    = '0;
         current_cnt[i]  = '0;
         holdoff_left[i] = '0;
      end
   endfunction

   function void note_failure(string msg);
      failures++;
      if (failures <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function int pending();
      return owed_responses.size();
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SLOTS_IN_USE: begin
            slots_cfg = data[SLOT_CNT_W-1:0];
         end
         CSR_THRESH_SLOT0: begin
            thresh[0] = data;
         end
         CSR_THRESH_SLOT1: begin
            thresh[1] = data;
         end
         CSR_THRESH_SLOT2: begin
            thresh[2] = data;
         end
         CSR_THRESH_SLOT3: begin
            thresh[3] = data;
         end
         CSR_HOLDOFF: begin
            holdoff_reload = data[HOLDOFF_W-1:0];
         end
         default: ;
      endcase
   endfunction

   // Apply one accepted request to the slot table and queue its response
   function void note_request(req_type r);
      int      used;
      rsp_type e;
      used = (slots_cfg == 0) ? 1 : ((slots_cfg > NUM_SLOTS) ? NUM_SLOTS : slots_cfg);
      e = '0;
      case (r.kind)
         KIND_SCAN: begin
            // an active slot left beyond the rotation still takes the sample
            if (active < NUM_SLOTS) begin
               prior_cnt[active]   = current_cnt[active];
               current_cnt[active] = r.count;
            end
            active++;
            if (active >= used) begin
               active = 0;
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < used; i++) begin
               if (holdoff_left[i] != 0) begin
                  holdoff_left[i]--;
               end
            end
         end
         KIND_CHECK: begin
            // slots outside the rotation report no difference and no touch
            if (r.slot < used) begin
               e.difference = prior_cnt[r.slot] - current_cnt[r.slot];
               if (e.difference > thresh[r.slot] && holdoff_left[r.slot] == 0) begin
                  holdoff_left[r.slot] = holdoff_reload;
                  e.touched = 1'b1;
               end
            end
         end
         default: ;
      endcase
      e.next_slot = active[SLOT_W-1:0];
      owed_responses.push_back(e);
   endfunction

   function void check_response(rsp_type got);
      rsp_type e;
      if (owed_responses.size() == 0) begin
         note_failure($sformatf("unexpected response: touched %0b difference %0d next %0d",
                                got.touched, got.difference, got.next_slot));
         return;
      end
      e = owed_responses.pop_front();
      if (got.touched !== e.touched || got.difference !== e.difference ||
          got.next_slot !== e.next_slot) begin
         note_failure($sformatf({"response mismatch: touched %0b/%0b difference %0d/%0d ",
                                 "next %0d/%0d (expected/actual)"},
                                e.touched, got.touched, e.difference, got.difference,
                                e.next_slot, got.next_slot));
      end
   endfunction
endclass

module tb_cap_touch_delta_detector_unit;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Spare request kind, ignored by the block
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   touch_result_tracker tracker;

   cap_touch_delta_detector_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Response side: check what is taken, then stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            tracker.check_response(rsp_data);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Hard stop
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic req_type make_req(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] count,
                                        logic [SLOT_W-1:0] slot);
      req_type r;
      r.kind  = kind;
      r.count = count;
      r.slot  = slot;
      return r;
   endfunction

   // Mostly scans and checks around a baseline count, with ticks and the odd stray kind
   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      sel;
      pick    = $urandom_range(0, 99);
      sel     = $urandom_range(0, 7);
      r.count = 16'($urandom);
      r.slot  = 2'($urandom);
      if (pick < 45) begin
         r.kind = KIND_SCAN;
         case (sel)
            0: r.count = 16'd0;
            1: r.count = 16'hFFFF;
            2, 3: ;
            default: r.count = 16'(20000 + $urandom_range(0, 3000));
         endcase
      end else if (pick < 65) begin
         r.kind = KIND_TICK;
      end else if (pick < 95) begin
         r.kind = KIND_CHECK;
      end else begin
         r.kind = KIND_SPARE;
      end
      return r;
   endfunction

   task automatic set_idle_mode(int mode);
      case (mode)
         0: begin
            send_idle_pct = 21;
            recv_idle_pct = 46;
         end
         1: begin
            send_idle_pct = 46;
            recv_idle_pct = 21;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic send_request(req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(r);
   endtask

   // Leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   // Drain all owed responses, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic configure_phase(int phase);
      logic [SLOT_CNT_W-1:0]     slots;
      logic [HOLDOFF_W-1:0]      hold;
      logic [CSR_DATA_W-1:0]     thr [NUM_SLOTS];
      for (int i = 0; i < NUM_SLOTS; i++) begin
         thr[i] = 16'($urandom_range(0, 4000) - 1000);
      end
      case (phase)
         0: begin
            slots  = 3'd4;
            hold   = 8'd3;
            thr[0] = 16'd500;
            thr[1] = 16'h8000;
            thr[2] = 16'h7FFF;
            thr[3] = 16'd0;
         end
         1: begin
            slots = 3'd3;
            hold  = 8'd0;
         end
         2: begin
            slots = 3'd1;
            hold  = 8'd255;
         end
         3: begin
            slots = 3'd7;
            hold  = 8'd1;
         end
         4: begin
            slots = 3'd0;
            hold  = 8'd5;
         end
         default: begin
            slots = 3'd2;
            hold  = 8'd2;
         end
      endcase
      // unused upper bits carry junk
      write_reg(CSR_SLOTS_IN_USE, (16'($urandom) & 16'hFFF8) | 16'(slots));
      write_reg(CSR_THRESH_SLOT0, thr[0]);
      write_reg(CSR_THRESH_SLOT1, thr[1]);
      write_reg(CSR_THRESH_SLOT2, thr[2]);
      write_reg(CSR_THRESH_SLOT3, thr[3]);
      write_reg(CSR_HOLDOFF, (16'($urandom) & 16'hFF00) | 16'(hold));
      csr_write_en <= 1'b0;
   endtask

   initial begin
      tracker = new();
      set_idle_mode(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: check before any sample, stray kind, full rotation of extremes
      send_request(make_req(KIND_CHECK, 16'hFFFF, 2'd0));
      send_request(make_req(KIND_SPARE, 16'hFFFF, 2'd3));
      send_request(make_req(KIND_SCAN, 16'hFFFF, 2'd3));
      send_request(make_req(KIND_SCAN, 16'h0000, 2'd0));
      send_request(make_req(KIND_SCAN, 16'h8000, 2'd1));
      send_request(make_req(KIND_SCAN, 16'h7FFF, 2'd2));
      // touch on slot 0, then blocked by its hold-off
      send_request(make_req(KIND_CHECK, 16'h0000, 2'd0));
      send_request(make_req(KIND_CHECK, 16'h1234, 2'd0));
      send_request(make_req(KIND_CHECK, 16'h0000, 2'd1));
      send_request(make_req(KIND_CHECK, 16'h0000, 2'd2));
      send_request(make_req(KIND_CHECK, 16'h0000, 2'd3));
      send_request(make_req(KIND_TICK, 16'h0000, 2'd0));
      // park the active slot on 3
      send_request(make_req(KIND_SCAN, 16'h0000, 2'd0));
      send_request(make_req(KIND_SCAN, 16'd100, 2'd0));
      send_request(make_req(KIND_SCAN, 16'd200, 2'd0));

      // Shrink the rotation under the active slot; zero hold-off; threshold extremes
      wait_idle();
      write_reg(CSR_SLOTS_IN_USE, 16'd2);
      write_reg(CSR_THRESH_SLOT0, 16'h7FFF);
      write_reg(CSR_THRESH_SLOT1, 16'h8000);
      write_reg(CSR_HOLDOFF, 16'd0);
      csr_write_en <= 1'b0;
      send_request(make_req(KIND_SCAN, 16'd5, 2'd0));
      send_request(make_req(KIND_CHECK, 16'h0000, 2'd3));
      send_request(make_req(KIND_CHECK, 16'h0000, 2'd1));
      send_request(make_req(KIND_CHECK, 16'h0000, 2'd1));
      send_request(make_req(KIND_CHECK, 16'h0000, 2'd0));
      send_request(make_req(KIND_TICK, 16'hFFFF, 2'd3));
      send_request(make_req(KIND_SPARE, 16'h0000, 2'd0));

      // Random phases, each with its own register setting; pairs of phases share an idling mode
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         set_idle_mode(phase / 2);
         configure_phase(phase);
         repeat (155) send_request(random_request());
      end

      req_valid <= 1'b0;
      for (int n = 0; n < 1000 && tracker.pending() != 0; n++) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (tracker.pending() != 0) begin
         tracker.note_failure($sformatf("%0d responses never arrived", tracker.pending()));
      end
      if (tracker.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
